@@ rtl/core/odl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered deque list package
// Shared sizes, action and status codes, and the compare result type.
// ----------------------------------------------------------------------------
package odl_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ACT_W  = 3;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ORD_INSERT = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_REMOVE     = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic eq;  // entry equals the value
        logic lt;  // entry is less than the value (signed)
        logic gt;  // entry is greater than the value (signed)
    } cmp_t;

endpackage
`default_nettype wire

@@ rtl/core/odl_cmp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered deque list compare unit
// Signed compare of one stored entry against the operand value.
// ----------------------------------------------------------------------------
module odl_cmp (
    input  wire logic [odl_pkg::DATA_W-1:0] entry,
    input  wire logic [odl_pkg::DATA_W-1:0] operand,
    output odl_pkg::cmp_t                   result
);

    always_comb
    begin
        result.eq = (entry == operand);
        result.lt = ($signed(entry) < $signed(operand));
        result.gt = ($signed(entry) > $signed(operand));
    end

endmodule
`default_nettype wire

@@ rtl/core/ordered_deque_list_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered deque list engine
// Bounded list of signed 32-bit values in a one-read, one-write entry memory, walked
// and shifted one entry at a time by a small sequencer and one compare unit.
// ----------------------------------------------------------------------------
// Pop back, unused and rejected actions raise done in the cycle after the start beat;
// push back first writes its value in the up-read state. A search visits each entry in a
// fetch and a test state, a shift moves each entry in a read and a write state; the entry
// memory does one read and one write per cycle. busy is high while the sequencer is out
// of idle, through the done cycle but not on the start beat itself; a new start is taken
// the cycle after done. Reset empties the list and returns to idle.
module ordered_deque_list_engine (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [odl_pkg::ACT_W-1:0]           action,
    input  wire logic signed [odl_pkg::DATA_W-1:0]   value,
    output logic                                     busy,
    output logic                                     done,
    output logic [odl_pkg::STAT_W-1:0]               status,
    output logic [odl_pkg::OCC_W-1:0]                occupancy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_TEST  = 3'd2;
    localparam logic [2:0] S_UP_RD = 3'd3;
    localparam logic [2:0] S_UP_WR = 3'd4;
    localparam logic [2:0] S_DN_RD = 3'd5;
    localparam logic [2:0] S_DN_WR = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam logic [1:0] PH_HEAD = 2'd0;
    localparam logic [1:0] PH_TAIL = 2'd1;
    localparam logic [1:0] PH_MID  = 2'd2;

    localparam int IW = odl_pkg::IDX_W;
    localparam int CW = odl_pkg::CNT_W;
    localparam int DW = odl_pkg::DATA_W;

    logic [2:0]                    state_reg,  state_next;
    logic [1:0]                    phase_reg,  phase_next;
    logic [IW-1:0]                 idx_reg,    idx_next;
    logic [IW-1:0]                 pos_reg,    pos_next;
    logic [CW-1:0]                 count_reg,  count_next;
    logic [odl_pkg::STAT_W-1:0]    status_reg, status_next;
    logic [odl_pkg::ACT_W-1:0]     act_reg,    act_next;
    logic [DW-1:0]                 val_reg,    val_next;

    logic [DW-1:0]                 mem [odl_pkg::DEPTH];
    logic [DW-1:0]                 rdata_reg;
    logic                          mem_we;
    logic [IW-1:0]                 mem_waddr;
    logic [IW-1:0]                 mem_raddr;
    logic [DW-1:0]                 mem_wdata;

    odl_pkg::cmp_t                 cmp;
    logic [CW-1:0]                 cnt_m1;
    logic [CW-1:0]                 idx_p1;
    logic [CW-1:0]                 idx_p2;
    logic                          full;

    odl_cmp u_cmp (
        .entry   (rdata_reg),
        .operand (val_reg),
        .result  (cmp)
    );

    assign cnt_m1 = count_reg - CW'(1);
    assign idx_p1 = CW'(idx_reg) + CW'(1);
    assign idx_p2 = CW'(idx_reg) + CW'(2);
    assign full   = (count_reg == CW'(odl_pkg::DEPTH));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        status_next = status_reg;
        act_next    = act_reg;
        val_next    = val_reg;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg;
        mem_wdata   = rdata_reg;
        mem_raddr   = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    act_next    = action;
                    val_next    = value;
                    status_next = odl_pkg::ST_OK;
                    state_next  = S_DONE;
                    phase_next  = PH_HEAD;
                    unique case (action)
                        odl_pkg::ACT_PUSH_FRONT,
                        odl_pkg::ACT_PUSH_BACK,
                        odl_pkg::ACT_ORD_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = odl_pkg::ST_FULL;
                            end
                            else if (action == odl_pkg::ACT_ORD_INSERT && count_reg != '0)
                            begin
                                idx_next   = '0;
                                state_next = S_FETCH;
                            end
                            else
                            begin
                                // Insert at the front, or at the back for a push back.
                                idx_next   = count_reg[IW-1:0];
                                pos_next   = (action == odl_pkg::ACT_PUSH_BACK) ?
                                             count_reg[IW-1:0] : '0;
                                state_next = S_UP_RD;
                            end
                        end
                        odl_pkg::ACT_POP_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = odl_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_DN_RD;
                            end
                        end
                        odl_pkg::ACT_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = odl_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = cnt_m1;
                            end
                        end
                        odl_pkg::ACT_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = odl_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_FETCH;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_FETCH:
            begin
                mem_raddr  = idx_reg;
                state_next = S_TEST;
            end

            S_TEST:
            begin
                if (act_reg == odl_pkg::ACT_ORD_INSERT)
                begin
                    state_next = S_UP_RD;
                    idx_next   = count_reg[IW-1:0];
                    unique case (phase_reg)
                        PH_HEAD:
                        begin
                            if (cmp.gt)
                            begin
                                pos_next = '0;
                            end
                            else
                            begin
                                phase_next = PH_TAIL;
                                idx_next   = cnt_m1[IW-1:0];
                                state_next = S_FETCH;
                            end
                        end
                        PH_TAIL:
                        begin
                            if (cmp.lt || count_reg == CW'(1))
                            begin
                                pos_next = count_reg[IW-1:0];
                            end
                            else
                            begin
                                phase_next = PH_MID;
                                idx_next   = IW'(1);
                                state_next = S_FETCH;
                            end
                        end
                        default:
                        begin
                            // Interior walk: stop at the first entry not below the value.
                            if (!cmp.lt)
                            begin
                                pos_next = idx_reg;
                            end
                            else if (idx_p1 >= count_reg)
                            begin
                                pos_next = count_reg[IW-1:0];
                            end
                            else
                            begin
                                idx_next   = idx_p1[IW-1:0];
                                state_next = S_FETCH;
                            end
                        end
                    endcase
                end
                else
                begin
                    unique case (phase_reg)
                        PH_HEAD:
                        begin
                            if (cmp.eq)
                            begin
                                idx_next   = '0;
                                state_next = S_DN_RD;
                            end
                            else
                            begin
                                phase_next = PH_TAIL;
                                idx_next   = cnt_m1[IW-1:0];
                                state_next = S_FETCH;
                            end
                        end
                        PH_TAIL:
                        begin
                            if (cmp.eq)
                            begin
                                count_next = cnt_m1;
                                state_next = S_DONE;
                            end
                            else if (count_reg < CW'(3))
                            begin
                                status_next = odl_pkg::ST_NOT_FOUND;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                phase_next = PH_MID;
                                idx_next   = IW'(1);
                                state_next = S_FETCH;
                            end
                        end
                        default:
                        begin
                            if (cmp.eq)
                            begin
                                state_next = S_DN_RD;
                            end
                            else if (idx_p2 >= count_reg)
                            begin
                                status_next = odl_pkg::ST_NOT_FOUND;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                idx_next   = idx_p1[IW-1:0];
                                state_next = S_FETCH;
                            end
                        end
                    endcase
                end
            end

            S_UP_RD:
            begin
                // Entries above the slot move up one place, top first.
                if (idx_reg == pos_reg)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = pos_reg;
                    mem_wdata  = val_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    mem_raddr  = idx_reg - IW'(1);
                    state_next = S_UP_WR;
                end
            end

            S_UP_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = rdata_reg;
                idx_next   = idx_reg - IW'(1);
                state_next = S_UP_RD;
            end

            S_DN_RD:
            begin
                // Entries above the removed slot move down one place.
                if (idx_p1 < count_reg)
                begin
                    mem_raddr  = idx_p1[IW-1:0];
                    state_next = S_DN_WR;
                end
                else
                begin
                    count_next = cnt_m1;
                    state_next = S_DONE;
                end
            end

            S_DN_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = rdata_reg;
                idx_next   = idx_p1[IW-1:0];
                state_next = S_DN_RD;
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_HEAD;
            idx_reg    <= '0;
            pos_reg    <= '0;
            count_reg  <= '0;
            status_reg <= odl_pkg::ST_OK;
            act_reg    <= odl_pkg::ACT_PUSH_FRONT;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            pos_reg    <= pos_next;
            count_reg  <= count_next;
            status_reg <= status_next;
            act_reg    <= act_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = (state_reg == S_DONE);
    assign status    = status_reg;
    assign occupancy = odl_pkg::OCC_W'(count_reg);

endmodule
`default_nettype wire

@@ rtl/core/odl_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered deque list port checker
// Watches the command and result ports of the list engine over time.
// ----------------------------------------------------------------------------
module odl_chk (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic                         busy,
    input  wire logic                         done,
    input  wire logic [odl_pkg::STAT_W-1:0]   status,
    input  wire logic [odl_pkg::OCC_W-1:0]    occupancy
);

    // An accepted command keeps the engine busy through its result beat.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("engine not busy after an accepted command");

    // Each result beat lasts one cycle and the engine is free right after.
    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("engine still busy after its result beat");

    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (occupancy <= odl_pkg::OCC_W'(odl_pkg::DEPTH)))
        else $error("occupancy beyond the list depth");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == odl_pkg::ST_FULL) |->
            (occupancy == odl_pkg::OCC_W'(odl_pkg::DEPTH)))
        else $error("full status reported on a list that is not full");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == odl_pkg::ST_EMPTY) |-> (occupancy == '0))
        else $error("empty status reported on a list that holds entries");

endmodule

bind ordered_deque_list_engine odl_chk u_odl_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .status    (status),
    .occupancy (occupancy)
);
`default_nettype wire

@@ tb/tb_ordered_deque_list_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered deque list engine testbench
// Drives list actions through the start/busy handshake, keeps a shadow copy
// of the list to predict status and occupancy, and checks every done beat in
// order. A short directed table covers the empty and full cases, the end
// values and the removal order. Random bursts with gaps then sweep the list
// between empty and full.
// ----------------------------------------------------------------------------
module tb_ordered_deque_list_engine;

    // Action codes that the block leaves without effect.
    localparam logic [odl_pkg::ACT_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [odl_pkg::ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    localparam logic [odl_pkg::DATA_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [odl_pkg::DATA_W-1:0] VAL_MAX = 32'h7fff_ffff;

    localparam int RANDOM_ITEMS = 1800;
    localparam int PAUSE_AT     = 900;
    localparam int DRAIN_CYCLES = 4 * odl_pkg::DEPTH + 8;
    localparam int CYCLE_LIMIT  = 1_000_000;

    typedef struct packed {
        logic [odl_pkg::STAT_W-1:0] st;
        logic [odl_pkg::OCC_W-1:0]  occ;
    } list_result_t;

    typedef struct packed {
        logic [odl_pkg::ACT_W-1:0]  act;
        logic [odl_pkg::DATA_W-1:0] val;
        logic [4:0]                 reps;
        logic                       typed;
        logic [odl_pkg::STAT_W-1:0] st;
        logic [odl_pkg::OCC_W-1:0]  occ;
    } stim_row_t;

    // Rows with typed set carry their own expected result; the rest use the
    // shadow list.
    localparam stim_row_t DIRECTED [25] = '{
        '{odl_pkg::ACT_POP_FRONT,  32'd0,   5'd1,  1'b1, odl_pkg::ST_EMPTY,     5'd0},
        '{odl_pkg::ACT_POP_BACK,   32'd0,   5'd1,  1'b1, odl_pkg::ST_EMPTY,     5'd0},
        '{odl_pkg::ACT_REMOVE,     32'd0,   5'd1,  1'b1, odl_pkg::ST_EMPTY,     5'd0},
        '{ACT_SPARE_LO,            32'd0,   5'd1,  1'b1, odl_pkg::ST_OK,        5'd0},
        '{ACT_SPARE_HI,    32'hffff_ffff,   5'd1,  1'b1, odl_pkg::ST_OK,        5'd0},
        '{odl_pkg::ACT_ORD_INSERT, 32'd5,   5'd1,  1'b1, odl_pkg::ST_OK,        5'd1},
        '{odl_pkg::ACT_ORD_INSERT, 32'd5,   5'd1,  1'b1, odl_pkg::ST_OK,        5'd2},
        '{odl_pkg::ACT_REMOVE,     32'd5,   5'd1,  1'b1, odl_pkg::ST_OK,        5'd1},
        '{odl_pkg::ACT_POP_BACK,   32'd0,   5'd1,  1'b1, odl_pkg::ST_OK,        5'd0},
        '{odl_pkg::ACT_PUSH_BACK,  32'd9,   5'd1,  1'b1, odl_pkg::ST_OK,        5'd1},
        '{odl_pkg::ACT_REMOVE,     32'd7,   5'd1,  1'b1, odl_pkg::ST_NOT_FOUND, 5'd1},
        '{odl_pkg::ACT_PUSH_FRONT, VAL_MIN, 5'd1,  1'b1, odl_pkg::ST_OK,        5'd2},
        '{odl_pkg::ACT_PUSH_BACK,  VAL_MAX, 5'd1,  1'b1, odl_pkg::ST_OK,        5'd3},
        '{odl_pkg::ACT_ORD_INSERT, 32'd0,   5'd1,  1'b0, odl_pkg::ST_OK,        5'd0},
        '{odl_pkg::ACT_ORD_INSERT, 32'hffff_ffff, 5'd1, 1'b0, odl_pkg::ST_OK,   5'd0},
        '{odl_pkg::ACT_ORD_INSERT, 32'd0,   5'd1,  1'b0, odl_pkg::ST_OK,        5'd0},
        '{odl_pkg::ACT_REMOVE,     32'd0,   5'd1,  1'b0, odl_pkg::ST_OK,        5'd0},
        '{odl_pkg::ACT_REMOVE,     VAL_MAX, 5'd1,  1'b0, odl_pkg::ST_OK,        5'd0},
        '{odl_pkg::ACT_REMOVE,     VAL_MIN, 5'd1,  1'b0, odl_pkg::ST_OK,        5'd0},
        '{odl_pkg::ACT_PUSH_BACK,  32'd3,   5'd13, 1'b0, odl_pkg::ST_OK,        5'd0},
        '{odl_pkg::ACT_PUSH_FRONT, VAL_MAX, 5'd1,  1'b1, odl_pkg::ST_FULL,      5'd16},
        '{odl_pkg::ACT_PUSH_BACK,  32'd0,   5'd1,  1'b1, odl_pkg::ST_FULL,      5'd16},
        '{odl_pkg::ACT_ORD_INSERT, 32'd0,   5'd1,  1'b1, odl_pkg::ST_FULL,      5'd16},
        '{odl_pkg::ACT_POP_FRONT,  32'd0,   5'd16, 1'b0, odl_pkg::ST_OK,        5'd0},
        '{odl_pkg::ACT_POP_FRONT,  32'd0,   5'd1,  1'b1, odl_pkg::ST_EMPTY,     5'd0}
    };

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              start = 1'b0;
    logic [odl_pkg::ACT_W-1:0]         action = '0;
    logic signed [odl_pkg::DATA_W-1:0] value = '0;
    logic                              busy;
    logic                              done;
    logic [odl_pkg::STAT_W-1:0]        status;
    logic [odl_pkg::OCC_W-1:0]         occupancy;

    logic signed [odl_pkg::DATA_W-1:0] shadow_list[$];
    list_result_t                      pending_results[$];
    int                                error_count = 0;
    int                                result_count = 0;
    int                                cycle_count = 0;
    bit                                filling = 1'b1;

    ordered_deque_list_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .action    (action),
        .value     (value),
        .busy      (busy),
        .done      (done),
        .status    (status),
        .occupancy (occupancy)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Applies one action to the shadow list and returns the expected result.
    function automatic list_result_t predict_list_action(
        input logic [odl_pkg::ACT_W-1:0] act,
        input logic signed [odl_pkg::DATA_W-1:0] val
    );
        list_result_t res;
        int           n;
        int           pos;

        n = shadow_list.size();
        res.st = odl_pkg::ST_OK;
        case (act)
            odl_pkg::ACT_PUSH_FRONT, odl_pkg::ACT_PUSH_BACK, odl_pkg::ACT_ORD_INSERT:
            begin
                if (n >= odl_pkg::DEPTH)
                    res.st = odl_pkg::ST_FULL;
                else if (act == odl_pkg::ACT_PUSH_FRONT)
                    shadow_list.push_front(val);
                else if (act == odl_pkg::ACT_PUSH_BACK)
                    shadow_list.push_back(val);
                else
                begin
                    if (n == 0 || val < shadow_list[0])
                        pos = 0;
                    else if (shadow_list[n-1] < val)
                        pos = n;
                    else
                    begin
                        // The first entry past the head that is not below the value.
                        pos = n;
                        for (int k = n - 1; k >= 1; k--)
                            if (shadow_list[k] >= val)
                                pos = k;
                    end
                    shadow_list.insert(pos, val);
                end
            end
            odl_pkg::ACT_POP_FRONT:
            begin
                if (n == 0)
                    res.st = odl_pkg::ST_EMPTY;
                else
                    void'(shadow_list.pop_front());
            end
            odl_pkg::ACT_POP_BACK:
            begin
                if (n == 0)
                    res.st = odl_pkg::ST_EMPTY;
                else
                    void'(shadow_list.pop_back());
            end
            odl_pkg::ACT_REMOVE:
            begin
                if (n == 0)
                    res.st = odl_pkg::ST_EMPTY;
                else if (shadow_list[0] == val)
                    shadow_list.delete(0);
                else if (shadow_list[n-1] == val)
                    shadow_list.delete(n - 1);
                else
                begin
                    // Head and tail are already ruled out; take the first interior match.
                    pos = -1;
                    for (int k = n - 2; k >= 1; k--)
                        if (shadow_list[k] == val)
                            pos = k;
                    if (pos < 0)
                        res.st = odl_pkg::ST_NOT_FOUND;
                    else
                        shadow_list.delete(pos);
                end
            end
            default:
            begin
            end
        endcase
        res.occ = odl_pkg::OCC_W'(shadow_list.size());
        return res;
    endfunction

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Presents one beat and holds it until the block takes it.
    task automatic send_item(
        input logic [odl_pkg::ACT_W-1:0] act,
        input logic signed [odl_pkg::DATA_W-1:0] val,
        input bit typed,
        input list_result_t typed_res
    );
        list_result_t predicted;

        @(negedge clk);
        start  <= 1'b1;
        action <= act;
        value  <= val;
        do
            @(posedge clk);
        while (busy);
        predicted = predict_list_action(act, val);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // Mostly small values so that duplicates and matches are common.
    function automatic logic signed [odl_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return $signed($urandom_range(0, 15)) - 8;
        endcase
    endfunction

    always @(posedge clk)
    begin
        list_result_t exp_res;

        if (rst_n && done)
        begin
            result_count++;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("done beat %0d with nothing expected", result_count));
            else
            begin
                exp_res = pending_results.pop_front();
                if (status !== exp_res.st)
                    report_mismatch($sformatf("beat %0d status %0d, expected %0d",
                                              result_count, status, exp_res.st));
                if (occupancy !== exp_res.occ)
                    report_mismatch($sformatf("beat %0d occupancy %0d, expected %0d",
                                              result_count, occupancy, exp_res.occ));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL ordered_deque_list_engine");
            $finish;
        end
    end

    initial
    begin
        logic [odl_pkg::ACT_W-1:0]         act;
        logic signed [odl_pkg::DATA_W-1:0] val;
        int                                sent;
        int                                burst;
        int                                r;

        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED[i])
        begin
            for (int rep = 0; rep < DIRECTED[i].reps; rep++)
                send_item(DIRECTED[i].act, $signed(DIRECTED[i].val), DIRECTED[i].typed,
                          '{DIRECTED[i].st, DIRECTED[i].occ});
            idle_cycles($urandom_range(0, 2));
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++)
            begin
                // Sweep between empty and full, with an occasional change of mind.
                if (shadow_list.size() >= odl_pkg::DEPTH)
                    filling = 1'b0;
                else if (shadow_list.size() == 0)
                    filling = 1'b1;
                else if ($urandom_range(0, 49) == 0)
                    filling = !filling;

                r = $urandom_range(0, 99);
                val = pick_value();
                if (r < 3)
                    act = r[0] ? ACT_SPARE_HI : ACT_SPARE_LO;
                else if ((r < 68) == filling)
                begin
                    case ($urandom_range(0, 3))
                        0: act = odl_pkg::ACT_PUSH_FRONT;
                        1: act = odl_pkg::ACT_PUSH_BACK;
                        default: act = odl_pkg::ACT_ORD_INSERT;
                    endcase
                end
                else
                begin
                    case ($urandom_range(0, 3))
                        0: act = odl_pkg::ACT_POP_FRONT;
                        1: act = odl_pkg::ACT_POP_BACK;
                        default:
                        begin
                            act = odl_pkg::ACT_REMOVE;
                            if (shadow_list.size() != 0 && $urandom_range(0, 3) != 0)
                                val = shadow_list[$urandom_range(0, shadow_list.size() - 1)];
                        end
                    endcase
                end
                send_item(act, val, 1'b0, '0);
                sent++;

                if (sent == PAUSE_AT)
                begin
                    idle_cycles(1);
                    while (pending_results.size() != 0)
                        @(posedge clk);
                end
            end
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 10));
        end

        idle_cycles(1);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("PASS ordered_deque_list_engine");
        else
            $display("FAIL ordered_deque_list_engine");
        $finish;
    end

endmodule
